// ===== rtl/core/mcsq_pkg.sv =====
// Package for the MCS queue lock manager: sizes, command and status codes, FSM states.
package mcsq_pkg;

  localparam int unsigned NUM_PES = 64;
  localparam int unsigned PE_W    = 6;

  // requester count at one bit over the field width, for range checks
  localparam logic [PE_W:0] PE_COUNT = (PE_W + 1)'(NUM_PES);

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_TEST  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_QUEUED   = 2'd1,
    ST_BUSY     = 2'd2,
    ST_RELEASED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEND_FIRST,
    S_SEND_SECOND
  } state_t;

endpackage

// ===== rtl/core/mcs_queue_lock_manager_top.sv =====
// Top level of the MCS queue lock manager.
// Hardware manager for one MCS queue lock shared by 64 requesters. Each item
// carries a command (set, clear, test) and a requester number and produces one
// result, or two for a clear that hands the lock to a queued successor (release
// to the holder, then grant to the successor, last_result marking the final
// one). Items are handled one at a time: an item is taken in while the
// successor RAM is read, then executed against the tail word and the
// successor links, and then each of its results is sent, held for as long
// as the output side stalls. The tail word and the successor valid bits are
// flip-flops cleared by reset; successor numbers live in a synchronous RAM
// that is only read behind a set valid bit, so it needs no clearing after
// reset.
module mcs_queue_lock_manager_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              command,
  input  logic [mcsq_pkg::PE_W-1:0] requester_pe,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [mcsq_pkg::PE_W-1:0] target_pe,
  output logic [1:0]              status,
  output logic                    last_result
);

  localparam int PW = mcsq_pkg::PE_W;

  mcsq_pkg::state_t state, state_next;

  // captured item
  logic [1:0]    cmd;
  logic [PW-1:0] me;

  // lock state
  logic                            tail_locked, tail_locked_next;
  logic [PW-1:0]                   tail_pe, tail_pe_next;
  logic [mcsq_pkg::NUM_PES-1:0]    succ_valid, succ_valid_next;

  // result registers
  logic [PW-1:0]           res_pe, res_pe_next;
  mcsq_pkg::status_t       res_status, res_status_next;
  logic                    res_last, res_last_next;
  logic [PW-1:0]           res2_pe, res2_pe_next;

  // successor RAM
  logic          ram_we;
  logic [PW-1:0] ram_waddr, ram_wdata, ram_rdata;

  logic me_in_range, old_in_range;

  mcsq_ram #(
    .WIDTH(PW),
    .DEPTH(mcsq_pkg::NUM_PES)
  ) u_succ_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(requester_pe),
    .rdata(ram_rdata)
  );

  assign in_ready    = (state == mcsq_pkg::S_IDLE);
  assign out_valid   = (state == mcsq_pkg::S_SEND_FIRST) || (state == mcsq_pkg::S_SEND_SECOND);
  assign target_pe   = res_pe;
  assign status      = res_status;
  assign last_result = res_last;

  assign me_in_range  = ({1'b0, me} < mcsq_pkg::PE_COUNT);
  assign old_in_range = ({1'b0, tail_pe} < mcsq_pkg::PE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mcsq_pkg::S_IDLE;
      tail_locked <= 1'b0;
      tail_pe     <= '0;
      succ_valid  <= '0;
    end else begin
      state       <= state_next;
      tail_locked <= tail_locked_next;
      tail_pe     <= tail_pe_next;
      succ_valid  <= succ_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= command;
      me  <= requester_pe;
    end
    res_pe     <= res_pe_next;
    res_status <= res_status_next;
    res_last   <= res_last_next;
    res2_pe    <= res2_pe_next;
  end

  always_comb begin
    state_next       = state;
    tail_locked_next = tail_locked;
    tail_pe_next     = tail_pe;
    succ_valid_next  = succ_valid;
    res_pe_next      = res_pe;
    res_status_next  = res_status;
    res_last_next    = res_last;
    res2_pe_next     = res2_pe;
    ram_we           = 1'b0;
    ram_waddr        = tail_pe;
    ram_wdata        = me;

    unique case (state)
      mcsq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = mcsq_pkg::S_EXEC;
        end
      end

      mcsq_pkg::S_EXEC: begin
        res_pe_next     = me;
        res_status_next = mcsq_pkg::ST_BUSY;
        res_last_next   = 1'b1;
        state_next      = mcsq_pkg::S_SEND_FIRST;
        if (me_in_range) begin
          case (cmd)
            mcsq_pkg::CMD_SET: begin
              tail_locked_next    = 1'b1;
              tail_pe_next        = me;
              succ_valid_next[me] = 1'b0;
              if (tail_locked && old_in_range) begin
                // link behind the old tail; may be the requester itself
                ram_we                   = 1'b1;
                succ_valid_next[tail_pe] = 1'b1;
                res_status_next          = mcsq_pkg::ST_QUEUED;
              end else begin
                res_status_next = mcsq_pkg::ST_GRANTED;
              end
            end
            mcsq_pkg::CMD_TEST: begin
              if (!tail_locked) begin
                tail_locked_next    = 1'b1;
                tail_pe_next        = me;
                succ_valid_next[me] = 1'b0;
                res_status_next     = mcsq_pkg::ST_GRANTED;
              end
            end
            mcsq_pkg::CMD_CLEAR: begin
              res_status_next = mcsq_pkg::ST_RELEASED;
              if (!succ_valid[me]) begin
                if (tail_locked && (tail_pe == me)) begin
                  tail_locked_next = 1'b0;
                  tail_pe_next     = '0;
                end
              end else begin
                // hand off: release now, grant the successor next
                succ_valid_next[me] = 1'b0;
                res_last_next       = 1'b0;
                res2_pe_next        = ram_rdata;
              end
            end
            default: begin
              res_status_next = mcsq_pkg::ST_BUSY;
            end
          endcase
        end
      end

      mcsq_pkg::S_SEND_FIRST: begin
        if (out_ready) begin
          if (res_last) begin
            state_next = mcsq_pkg::S_IDLE;
          end else begin
            res_pe_next     = res2_pe;
            res_status_next = mcsq_pkg::ST_GRANTED;
            res_last_next   = 1'b1;
            state_next      = mcsq_pkg::S_SEND_SECOND;
          end
        end
      end

      mcsq_pkg::S_SEND_SECOND: begin
        if (out_ready) begin
          state_next = mcsq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = mcsq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mcsq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
